// ===== rtl/apd_pkg.sv =====
// shared constants, types and configuration layout of the averaged pid duty block
package apd_pkg;

    localparam int SAMPLES_PER_STEP = 30;
    localparam int SAMPLE_BITS      = 10;

    localparam int SAMPLE_W   = 10;
    localparam int SUM_W      = 16;
    localparam int COUNT_W    = 6;
    localparam int ERR_W      = 11;
    localparam int DIFF_W     = 12;
    localparam int ESUM_W     = 24;
    localparam int GAIN_W     = 16;
    localparam int DUTY_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK  = SAMPLE_W'((1 << SAMPLE_BITS) - 1);
    localparam logic [COUNT_W-1:0]  COUNT_TARGET = COUNT_W'(SAMPLES_PER_STEP % 64);

    // block mean by reciprocal multiply, one correction step
    localparam int              DIV_SHIFT = 16;
    localparam int              RECIP_W   = 17;
    localparam logic [RECIP_W-1:0] RECIP  = RECIP_W'((2 ** DIV_SHIFT) / SAMPLES_PER_STEP);
    localparam logic [SUM_W-1:0]   DIVISOR = SUM_W'(SAMPLES_PER_STEP);
    localparam int              PROD_W    = SUM_W + RECIP_W;

    localparam logic signed [ESUM_W-1:0] INTEG_MAX = {1'b0, {(ESUM_W-1){1'b1}}};
    localparam logic signed [ESUM_W-1:0] INTEG_MIN = {1'b1, {(ESUM_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET = 3'd0,
        REG_KP     = 3'd1,
        REG_KI     = 3'd2,
        REG_KD     = 3'd3,
        REG_GATE   = 3'd4,
        REG_BASE   = 3'd5,
        REG_PERIOD = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [SAMPLE_W-1:0] target;
        logic [GAIN_W-1:0]   kp;
        logic [GAIN_W-1:0]   ki;
        logic [GAIN_W-1:0]   kd;
        logic [SAMPLE_W-1:0] gate;
        logic [DUTY_W-1:0]   base;
        logic [DUTY_W-1:0]   period;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        target: 10'd927,
        kp:     16'd2560,
        ki:     16'd2560,
        kd:     16'd0,
        gate:   10'd40,
        base:   16'd4500,
        period: 16'd20000
    };

    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] sum;
    } t_push;

    typedef struct packed {
        logic             empty;
        logic             full;
        logic [SUM_W-1:0] head;
    } t_q_stat;

endpackage

// ===== rtl/apd_if.sv =====
// sample and result channel interfaces
interface apd_sample_if;
    import apd_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface apd_result_if;
    import apd_pkg::*;
    logic                valid;
    logic                ready;
    logic [DUTY_W-1:0]   duty;
    logic [SAMPLE_W-1:0] average;
    logic                clamped;
    modport source (output valid, output duty, output average, output clamped, input ready);
    modport sink   (input valid, input duty, input average, input clamped, output ready);
endinterface

// ===== rtl/apd_front.sv =====
// front end: block accumulation of samples, hands completed block sums to the queue
module apd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    apd_sample_if.sink      i_in,
    input  logic            i_q_full,
    output apd_pkg::t_push  o_push
);
    import apd_pkg::*;

    logic [SUM_W-1:0]   r_sum;
    logic [COUNT_W-1:0] r_count;
    logic [SUM_W-1:0]   n_sum;
    logic [COUNT_W-1:0] n_count;
    logic               w_take;
    logic               w_done;

    assign i_in.ready = !i_q_full;
    assign w_take     = i_in.valid && i_in.ready;
    assign n_sum      = r_sum + SUM_W'(i_in.sample & SAMPLE_MASK);
    assign n_count    = r_count + COUNT_W'(1);
    assign w_done     = (n_count == COUNT_TARGET);

    assign o_push.valid = w_take && w_done;
    assign o_push.sum   = n_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
        end else if (w_take) begin
            r_sum   <= w_done ? '0 : n_sum;
            r_count <= w_done ? '0 : n_count;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_count} < 7'(SAMPLES_PER_STEP)))
        else $error("block count past block length");

endmodule

// ===== rtl/apd_queue.sv =====
// short queue of block sums between front and back end
module apd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  apd_pkg::t_push   i_push,
    input  logic             i_pop,
    output apd_pkg::t_q_stat o_stat
);
    import apd_pkg::*;

    logic [SUM_W-1:0]  r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;

    function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push.valid) r_wr <= next_ptr(r_wr);
            if (i_pop)        r_rd <= next_ptr(r_rd);
            case ({i_push.valid, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= QCNT_W'(QUEUE_DEPTH)))
        else $error("queue count beyond depth");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.valid && !i_pop) |=> (r_count != '0))
        else $error("queue empty right after push");

endmodule

// ===== rtl/apd_back.sv =====
// back end: block mean, pid step with gated integral, duty clamp and output register
module apd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  apd_pkg::t_cfg    i_cfg,
    input  apd_pkg::t_q_stat i_q,
    output logic             o_pop,
    apd_result_if.source     o_out
);
    import apd_pkg::*;

    logic w_adv;

    // stage valids
    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    // stage 1: reciprocal product
    logic [SUM_W-1:0]  r_sum1;
    logic [PROD_W-1:0] r_prod1;

    // stage 2: mean and error
    logic [SUM_W-1:0]        w_q0;
    logic [SUM_W-1:0]        w_rem;
    logic [SUM_W-1:0]        w_q;
    logic [SAMPLE_W-1:0]     w_avg;
    logic [SAMPLE_W-1:0]     r_avg2;
    logic signed [ERR_W-1:0] r_e2;

    // stage 3: integrator state and derivative term
    logic signed [ESUM_W-1:0] r_esum;
    logic signed [ERR_W-1:0]  r_last_e;
    logic signed [ESUM_W:0]   w_t;
    logic signed [ESUM_W-1:0] w_esum;
    logic [SAMPLE_W-1:0]      r_avg3;
    logic signed [ERR_W-1:0]  r_e3;
    logic signed [ESUM_W-1:0] r_esum3;
    logic signed [DIFF_W-1:0] r_diff3;

    // stage 4: gain products
    localparam int PKP_W = GAIN_W + 1 + ERR_W;
    localparam int PKI_W = GAIN_W + 1 + ESUM_W;
    localparam int PKD_W = GAIN_W + 1 + DIFF_W;
    localparam int ACC_W = PKI_W + 1;
    localparam int DSUM_W = 36;
    logic signed [PKP_W-1:0] w_pkp, r_pkp4;
    logic signed [PKI_W-1:0] w_pki, r_pki4;
    logic signed [PKD_W-1:0] w_pkd, r_pkd4;
    logic [SAMPLE_W-1:0]     r_avg4;

    // stage 5: accumulated controller output
    logic signed [ACC_W-1:0] r_acc5;
    logic [SAMPLE_W-1:0]     r_avg5;

    // output stage
    logic signed [ACC_W-1:0]  w_sh;
    logic signed [DSUM_W-1:0] w_duty;
    logic signed [DSUM_W-1:0] w_period;
    logic [DUTY_W-1:0]        w_duty_c;
    logic                     w_clip;
    logic                     r_out_valid;
    logic [DUTY_W-1:0]        r_out_duty;
    logic [SAMPLE_W-1:0]      r_out_avg;
    logic                     r_out_clamped;

    // the whole pipe moves whenever the output register can take a new item
    assign w_adv = !r_out_valid || o_out.ready;
    assign o_pop = w_adv && !i_q.empty;

    assign w_q0  = SUM_W'(r_prod1 >> DIV_SHIFT);
    assign w_rem = r_sum1 - SUM_W'(w_q0 * DIVISOR);
    assign w_q   = (w_rem >= DIVISOR) ? w_q0 + SUM_W'(1) : w_q0;
    assign w_avg = w_q[SAMPLE_W-1:0];

    // gate compare and saturating integral add
    always_comb begin
        w_t = (ESUM_W + 1)'(r_esum) + (ESUM_W + 1)'(r_e2);
        if (r_e2 > $signed({1'b0, i_cfg.gate})) begin
            w_esum = r_esum;
        end else if (w_t > (ESUM_W + 1)'(INTEG_MAX)) begin
            w_esum = INTEG_MAX;
        end else if (w_t < (ESUM_W + 1)'(INTEG_MIN)) begin
            w_esum = INTEG_MIN;
        end else begin
            w_esum = ESUM_W'(w_t);
        end
    end

    assign w_pkp = $signed({1'b0, i_cfg.kp}) * r_e3;
    assign w_pki = $signed({1'b0, i_cfg.ki}) * r_esum3;
    assign w_pkd = $signed({1'b0, i_cfg.kd}) * r_diff3;

    // arithmetic shift rounds toward minus infinity
    always_comb begin
        w_sh     = r_acc5 >>> 8;
        w_duty   = DSUM_W'(w_sh) + $signed({{(DSUM_W-DUTY_W){1'b0}}, i_cfg.base});
        w_period = $signed({{(DSUM_W-DUTY_W){1'b0}}, i_cfg.period});
        if (w_duty < 0) begin
            w_duty_c = '0;
            w_clip   = 1'b1;
        end else if (w_duty > w_period) begin
            w_duty_c = i_cfg.period;
            w_clip   = 1'b1;
        end else begin
            w_duty_c = w_duty[DUTY_W-1:0];
            w_clip   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_out_valid <= 1'b0;
            r_esum      <= '0;
            r_last_e    <= '0;
        end else if (w_adv) begin
            r_v1        <= !i_q.empty;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_v4        <= r_v3;
            r_v5        <= r_v4;
            r_out_valid <= r_v5;
            if (r_v2) begin
                r_esum   <= w_esum;
                r_last_e <= r_e2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sum1  <= i_q.head;
            r_prod1 <= i_q.head * RECIP;
            r_avg2  <= w_avg;
            // mean never exceeds the sample range, so the error fits without saturation
            r_e2    <= $signed({1'b0, i_cfg.target}) - $signed({1'b0, w_avg});
            r_avg3  <= r_avg2;
            r_e3    <= r_e2;
            r_esum3 <= w_esum;
            r_diff3 <= DIFF_W'(r_e2) - DIFF_W'(r_last_e);
            r_avg4  <= r_avg3;
            r_pkp4  <= w_pkp;
            r_pki4  <= w_pki;
            r_pkd4  <= w_pkd;
            r_avg5  <= r_avg4;
            r_acc5  <= ACC_W'(r_pkp4) + ACC_W'(r_pki4) + ACC_W'(r_pkd4);
            if (r_v5) begin
                r_out_duty    <= w_duty_c;
                r_out_avg     <= r_avg5;
                r_out_clamped <= w_clip;
            end
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.duty    = r_out_duty;
    assign o_out.average = r_out_avg;
    assign o_out.clamped = r_out_clamped;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_clamped) |-> (r_out_duty <= i_cfg.period))
        else $error("unclamped duty above period");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_clamped) |->
            (r_out_duty == '0 || r_out_duty == i_cfg.period))
        else $error("clamped duty not at a limit");

endmodule

// ===== rtl/averaged_pid_pwm_duty.sv =====
// top level: averaged pid controller producing a clamped pwm compare count
// throughput: one sample per cycle; results go through a 5-stage back pipe and one output register
// the front stalls only when the 4-entry block queue is full behind a stalled output
// reset (synchronous, active low) clears sums, counts, integral, last error and all valids
// and loads the register defaults
module averaged_pid_pwm_duty (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    apd_sample_if.sink                        i_in,
    apd_result_if.source                      o_out,
    input  logic                              i_cfg_we,
    input  logic [apd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [apd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import apd_pkg::*;

    t_cfg    r_cfg;
    t_push   w_push;
    t_q_stat w_q;
    logic    w_pop;

    // register file, writes are masked to each register's width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_TARGET: r_cfg.target <= i_cfg_data[SAMPLE_W-1:0];
                REG_KP:     r_cfg.kp     <= i_cfg_data[GAIN_W-1:0];
                REG_KI:     r_cfg.ki     <= i_cfg_data[GAIN_W-1:0];
                REG_KD:     r_cfg.kd     <= i_cfg_data[GAIN_W-1:0];
                REG_GATE:   r_cfg.gate   <= i_cfg_data[SAMPLE_W-1:0];
                REG_BASE:   r_cfg.base   <= i_cfg_data[DUTY_W-1:0];
                REG_PERIOD: r_cfg.period <= i_cfg_data[DUTY_W-1:0];
                default:    r_cfg        <= r_cfg;
            endcase
        end
    end

    // front: sums each block of samples, pushes the sum when the block closes
    apd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (w_q.full),
        .o_push   (w_push)
    );

    // decouples sample intake from a stalled result consumer
    apd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_stat  (w_q)
    );

    // back: mean, pid step, clamp, output register
    apd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_q     (w_q),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && w_q.empty))
        else $error("pop from empty queue");

endmodule
